FILE: rtl/smeng_pkg.sv
// ----------------------------------------------------------------------------
// smeng_pkg
// Shared types and codes for the stable matching engine: payload structs,
// command codes and the sequencer state type.
// ----------------------------------------------------------------------------
package smeng_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_PROP = 2'd0,
    CMD_LOAD_ACC  = 2'd1,
    CMD_START     = 2'd2,
    CMD_NONE      = 2'd3
  } smeng_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] person;
    logic [3:0] rank;
    logic [3:0] choice;
  } smeng_in_t;

  typedef struct packed {
    logic [3:0] proposer;
    logic [3:0] partner;
    logic       last_pair;
  } smeng_out_t;

  // at most this many results follow a start
  localparam int MAX_RESULTS = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_POP,
    ST_RD_A,
    ST_RD_NR,
    ST_RD_B,
    ST_RD_PA,
    ST_RD_RA,
    ST_CMP,
    ST_WIN,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } smeng_state_t;

endpackage

FILE: rtl/smeng_ram.sv
// ----------------------------------------------------------------------------
// smeng_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smeng_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/stable_matching_engine_core.sv
// ----------------------------------------------------------------------------
// stable_matching_engine_core
// Proposer-side stable matching over loaded preference lists. Acceptor lists
// are stored inverted (rank per proposer). A sequencer walks a free stack and
// resolves one proposal at a time with a single shared comparator.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------
//   in_     | in  | in_valid/in_ready  | smeng_in_t  cmd, person, rank, choice
//   out_    | out | out_valid/out_ready| smeng_out_t proposer, partner, last
//   cfg_    | in  | cfg_we             | cfg_wdata   people_in_use
//
// A start first clears the tables for n people (n = people_in_use, clamped),
// then pops the free stack and runs each proposal as RAM reads through stack,
// next_rank, prefs, acceptor table and two rank reads, at most n*n proposals.
// Each result then passes read, load and hold states and waits on out_ready.
// in_ready is low from start until the last transfer out.
// Reset is synchronous; the preference RAMs are not cleared.
// ----------------------------------------------------------------------------
module stable_matching_engine_core #(
  parameter int MAX_PEOPLE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  smeng_pkg::smeng_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output smeng_pkg::smeng_out_t out_data,
  input  logic                  cfg_we,
  input  logic [4:0]            cfg_wdata
);

  localparam int IW  = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
  localparam int CW  = IW + 1;
  localparam int OPW = (CW > 4) ? CW : 4;
  localparam int PD  = 1 << (2 * IW);

  smeng_pkg::smeng_state_t state_r, state_nxt;
  logic [4:0]    piu_r, piu_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [IW-1:0] a_r, a_nxt;
  logic [IW-1:0] b_r, b_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [3:0]    rank_a_r, rank_a_nxt;
  logic          out_valid_r, out_valid_nxt;
  smeng_pkg::smeng_out_t out_data_r, out_data_nxt;

  // RAM ports
  logic            pref_we, rank_we, nr_we, pp_we, pa_we, stk_we;
  logic [2*IW-1:0] pref_waddr, pref_raddr, rank_waddr, rank_raddr;
  logic [3:0]      pref_wdata, pref_rdata, rank_wdata, rank_rdata;
  logic [IW-1:0]   nr_waddr, nr_raddr, pp_waddr, pp_raddr, pa_waddr, pa_raddr;
  logic [IW-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_rdata;
  logic [CW-1:0]   nr_wdata, nr_rdata;
  logic [IW:0]     pp_wdata, pp_rdata, pa_wdata, pa_rdata;

  // shared comparator
  logic [OPW-1:0] cmp_x, cmp_y;
  logic           cmp_lt;

  logic          in_fire;
  logic          clear_last, out_done;
  logic [IW-1:0] person_idx, rank_idx, choice_idx;
  logic          person_ok, rank_ok, choice_ok;

  assign in_ready  = (state_r == smeng_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign person_idx = IW'(in_data.person);
  assign rank_idx   = IW'(in_data.rank);
  assign choice_idx = IW'(in_data.choice);
  assign person_ok  = 32'(in_data.person) < MAX_PEOPLE;
  assign rank_ok    = 32'(in_data.rank) < MAX_PEOPLE;
  assign choice_ok  = 32'(in_data.choice) < MAX_PEOPLE;

  assign clear_last = (k_r + CW'(1)) == n_r;
  assign out_done   = ((k_r + CW'(1)) == n_r) ||
                      (32'(k_r) == smeng_pkg::MAX_RESULTS - 1);

  assign piu_nxt = cfg_we ? cfg_wdata : piu_r;

  always_comb begin
    unique case (state_r)
      smeng_pkg::ST_POP: begin
        cmp_x = OPW'(top_r);
        cmp_y = OPW'(1);
      end
      smeng_pkg::ST_RD_NR: begin
        cmp_x = OPW'(nr_rdata);
        cmp_y = OPW'(n_r);
      end
      smeng_pkg::ST_RD_B: begin
        cmp_x = OPW'(pref_rdata);
        cmp_y = OPW'(n_r);
      end
      smeng_pkg::ST_CMP: begin
        cmp_x = OPW'(rank_a_r);
        cmp_y = OPW'(rank_rdata);
      end
      default: begin
        cmp_x = '0;
        cmp_y = '0;
      end
    endcase
  end

  assign cmp_lt = cmp_x < cmp_y;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smeng_pkg::ST_IDLE: begin
        if (in_fire && in_data.cmd == smeng_pkg::CMD_START) begin
          state_nxt = smeng_pkg::ST_CLEAR;
        end
      end
      smeng_pkg::ST_CLEAR: begin
        if (clear_last) begin
          state_nxt = smeng_pkg::ST_POP;
        end
      end
      // stack empty when top < 1
      smeng_pkg::ST_POP:   state_nxt = cmp_lt ? smeng_pkg::ST_OUT_RD : smeng_pkg::ST_RD_A;
      smeng_pkg::ST_RD_A:  state_nxt = smeng_pkg::ST_RD_NR;
      smeng_pkg::ST_RD_NR: state_nxt = cmp_lt ? smeng_pkg::ST_RD_B : smeng_pkg::ST_POP;
      smeng_pkg::ST_RD_B:  state_nxt = cmp_lt ? smeng_pkg::ST_RD_PA : smeng_pkg::ST_POP;
      smeng_pkg::ST_RD_PA: state_nxt = pa_rdata[IW] ? smeng_pkg::ST_RD_RA : smeng_pkg::ST_POP;
      smeng_pkg::ST_RD_RA: state_nxt = smeng_pkg::ST_CMP;
      smeng_pkg::ST_CMP:   state_nxt = cmp_lt ? smeng_pkg::ST_WIN : smeng_pkg::ST_POP;
      smeng_pkg::ST_WIN:   state_nxt = smeng_pkg::ST_POP;
      smeng_pkg::ST_OUT_RD: state_nxt = smeng_pkg::ST_OUT_LD;
      smeng_pkg::ST_OUT_LD: state_nxt = smeng_pkg::ST_OUT_HOLD;
      smeng_pkg::ST_OUT_HOLD: begin
        if (out_ready) begin
          state_nxt = out_done ? smeng_pkg::ST_IDLE : smeng_pkg::ST_OUT_RD;
        end
      end
      default: state_nxt = smeng_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    n_nxt         = n_r;
    top_nxt       = top_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    rank_a_nxt    = rank_a_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pref_we    = 1'b0;
    pref_waddr = {person_idx, rank_idx};
    pref_wdata = in_data.choice;
    pref_raddr = {a_r, nr_rdata[IW-1:0]};
    rank_we    = 1'b0;
    rank_waddr = {person_idx, choice_idx};
    rank_wdata = in_data.rank;
    rank_raddr = {b_r, a_r};
    nr_we      = 1'b0;
    nr_waddr   = a_r;
    nr_wdata   = nr_rdata + CW'(1);
    nr_raddr   = stk_rdata;
    pp_we      = 1'b0;
    pp_waddr   = a_r;
    pp_wdata   = {1'b1, b_r};
    pp_raddr   = k_r[IW-1:0];
    pa_we      = 1'b0;
    pa_waddr   = b_r;
    pa_wdata   = {1'b1, a_r};
    pa_raddr   = IW'(pref_rdata);
    stk_we     = 1'b0;
    stk_waddr  = top_r[IW-1:0];
    stk_wdata  = a_r;
    stk_raddr  = IW'(top_r - CW'(1));

    unique case (state_r)
      smeng_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.cmd)
            smeng_pkg::CMD_LOAD_PROP: pref_we = person_ok && rank_ok;
            smeng_pkg::CMD_LOAD_ACC:  rank_we = person_ok && rank_ok && choice_ok;
            smeng_pkg::CMD_START: begin
              if (piu_r == 5'd0) begin
                n_nxt = CW'(1);
              end else if (32'(piu_r) > MAX_PEOPLE) begin
                n_nxt = CW'(MAX_PEOPLE);
              end else begin
                n_nxt = CW'(piu_r);
              end
              k_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      smeng_pkg::ST_CLEAR: begin
        // reset per-person tables and stack the proposers 0..n-1
        nr_we     = 1'b1;
        nr_waddr  = k_r[IW-1:0];
        nr_wdata  = '0;
        pp_we     = 1'b1;
        pp_waddr  = k_r[IW-1:0];
        pp_wdata  = '0;
        pa_we     = 1'b1;
        pa_waddr  = k_r[IW-1:0];
        pa_wdata  = '0;
        stk_we    = 1'b1;
        stk_waddr = k_r[IW-1:0];
        stk_wdata = k_r[IW-1:0];
        if (clear_last) begin
          top_nxt = n_r;
          k_nxt   = '0;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      smeng_pkg::ST_POP: begin
        if (!cmp_lt) begin
          top_nxt = top_r - CW'(1);
        end
      end
      smeng_pkg::ST_RD_A: begin
        a_nxt = stk_rdata;
      end
      smeng_pkg::ST_RD_NR: begin
        // cmp_lt: list not exhausted
        nr_we = cmp_lt;
      end
      smeng_pkg::ST_RD_B: begin
        if (cmp_lt) begin
          b_nxt = IW'(pref_rdata);
        end else begin
          // proposal to an acceptor outside the group: back on the stack
          stk_we  = 1'b1;
          top_nxt = top_r + CW'(1);
        end
      end
      smeng_pkg::ST_RD_PA: begin
        if (!pa_rdata[IW]) begin
          pa_we = 1'b1;
          pp_we = 1'b1;
        end else begin
          cur_nxt = pa_rdata[IW-1:0];
        end
      end
      smeng_pkg::ST_RD_RA: begin
        rank_a_nxt = rank_rdata;
        rank_raddr = {b_r, cur_r};
      end
      smeng_pkg::ST_CMP: begin
        stk_we  = 1'b1;
        top_nxt = top_r + CW'(1);
        if (cmp_lt) begin
          // newcomer wins: current partner is freed
          pp_we     = 1'b1;
          pp_waddr  = cur_r;
          pp_wdata  = '0;
          stk_wdata = cur_r;
          pa_we     = 1'b1;
        end
      end
      smeng_pkg::ST_WIN: begin
        pp_we = 1'b1;
      end
      smeng_pkg::ST_OUT_RD: ;
      smeng_pkg::ST_OUT_LD: begin
        out_data_nxt.proposer  = 4'(k_r);
        out_data_nxt.partner   = pp_rdata[IW] ? 4'(pp_rdata[IW-1:0]) : 4'd0;
        out_data_nxt.last_pair = (k_r + CW'(1)) == n_r;
        out_valid_nxt          = 1'b1;
      end
      smeng_pkg::ST_OUT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smeng_pkg::ST_IDLE;
      piu_r       <= 5'd16;
      n_r         <= CW'(1);
      top_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      piu_r       <= piu_nxt;
      n_r         <= n_nxt;
      top_r       <= top_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    cur_r      <= cur_nxt;
    rank_a_r   <= rank_a_nxt;
    out_data_r <= out_data_nxt;
  end

  smeng_ram #(.WIDTH(4), .DEPTH(PD)) u_pref_ram (
    .clk(clk), .we(pref_we), .waddr(pref_waddr), .wdata(pref_wdata),
    .raddr(pref_raddr), .rdata(pref_rdata)
  );

  smeng_ram #(.WIDTH(4), .DEPTH(PD)) u_rank_ram (
    .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
    .raddr(rank_raddr), .rdata(rank_rdata)
  );

  smeng_ram #(.WIDTH(CW), .DEPTH(MAX_PEOPLE)) u_nr_ram (
    .clk(clk), .we(nr_we), .waddr(nr_waddr), .wdata(nr_wdata),
    .raddr(nr_raddr), .rdata(nr_rdata)
  );

  smeng_ram #(.WIDTH(IW + 1), .DEPTH(MAX_PEOPLE)) u_pp_ram (
    .clk(clk), .we(pp_we), .waddr(pp_waddr), .wdata(pp_wdata),
    .raddr(pp_raddr), .rdata(pp_rdata)
  );

  smeng_ram #(.WIDTH(IW + 1), .DEPTH(MAX_PEOPLE)) u_pa_ram (
    .clk(clk), .we(pa_we), .waddr(pa_waddr), .wdata(pa_wdata),
    .raddr(pa_raddr), .rdata(pa_rdata)
  );

  smeng_ram #(.WIDTH(IW), .DEPTH(MAX_PEOPLE)) u_stk_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // accepting input and holding a result never overlap
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r)
    else $error("in_ready while a result is pending");

  // stack never grows past the group size
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smeng_pkg::ST_POP) |-> (top_r <= n_r))
    else $error("free stack overflow");

  // a proposer never steps past its list length
  a_nr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smeng_pkg::ST_RD_NR) |-> (nr_rdata <= n_r))
    else $error("next_rank beyond group size");

  // one result per transfer: valid drops right after the transfer
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready) |=> !out_valid_r)
    else $error("result repeated after transfer");

endmodule
